@@ rtl/pn_pkg.sv @@
package pn_pkg;

	// Buffer geometry
	localparam int PATH_BYTES  = 256;
	localparam int STK_ENTRIES = 64;
	localparam int ADDR_W      = $clog2(PATH_BYTES);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int SC_W        = $clog2(STK_ENTRIES + 1);
	localparam int SI_W        = (STK_ENTRIES > 1) ? $clog2(STK_ENTRIES) : 1;

	// Fixed field widths
	localparam int CH_W  = 8;
	localparam int LEN_W = 9;
	localparam int IDX_W = 8;

	localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;

	// Datapath operations
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
	localparam logic [OP_W-1:0] OP_TAKE_CH   = 4'd1;
	localparam logic [OP_W-1:0] OP_TAKE_CWD  = 4'd2;
	localparam logic [OP_W-1:0] OP_TAKE_SL   = 4'd3;
	localparam logic [OP_W-1:0] OP_JOB_START = 4'd4;
	localparam logic [OP_W-1:0] OP_MARK      = 4'd5;
	localparam logic [OP_W-1:0] OP_CLOSE     = 4'd6;
	localparam logic [OP_W-1:0] OP_FINISH    = 4'd7;
	localparam logic [OP_W-1:0] OP_RD_ADDR   = 4'd8;
	localparam logic [OP_W-1:0] OP_RD_EMIT   = 4'd9;

	typedef struct packed {
		logic            cmd;
		logic [CH_W-1:0] ch;
		logic            is_cwd;
		logic            last;
		logic [IDX_W-1:0] index;
	} pn_in_t;

	typedef struct packed {
		logic             status;
		logic [LEN_W-1:0] length;
		logic [CH_W-1:0]  out_char;
	} pn_out_t;

	typedef struct packed {
		logic            load;
		logic [OP_W-1:0] op;
	} pn_cmd_t;

	typedef struct packed {
		logic busy;
		logic out_free;
		logic item_cmd;
		logic ch_zero;
		logic ch_slash;
		logic is_cwd;
		logic last;
		logic path_started;
		logic cwd_seen;
		logic prev_slash;
	} pn_stat_t;

endpackage

@@ rtl/pn_ctrl.sv @@
module pn_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pn_pkg::pn_stat_t stat,
	output pn_pkg::pn_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PRE  = 3'd1;
	localparam logic [2:0] ST_MAIN = 3'd2;
	localparam logic [2:0] ST_LAST = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;
	localparam logic [2:0] ST_RDO  = 3'd5;

	logic [2:0] state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.op   = pn_pkg::OP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PRE;
				end
			end
			ST_PRE: begin
				if (!stat.busy) begin
					if (stat.item_cmd) begin
						cmd.op  = pn_pkg::OP_RD_ADDR;
						state_d = ST_RDO;
					end else if (stat.ch_zero) begin
						state_d = ST_LAST;
					end else if (stat.is_cwd) begin
						if (!stat.path_started)
							cmd.op = pn_pkg::OP_TAKE_CWD;
						state_d = ST_LAST;
					end else if (stat.path_started) begin
						cmd.op  = pn_pkg::OP_TAKE_CH;
						state_d = ST_LAST;
					end else if (stat.ch_slash) begin
						// absolute path: drop the working directory
						cmd.op  = pn_pkg::OP_JOB_START;
						state_d = ST_MAIN;
					end else if (!stat.cwd_seen || !stat.prev_slash) begin
						// boundary acts as a separator
						cmd.op  = pn_pkg::OP_TAKE_SL;
						state_d = ST_MAIN;
					end else begin
						cmd.op  = pn_pkg::OP_MARK;
						state_d = ST_MAIN;
					end
				end
			end
			ST_MAIN: begin
				if (!stat.busy) begin
					cmd.op  = pn_pkg::OP_TAKE_CH;
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				if (!stat.busy) begin
					if (stat.last) begin
						cmd.op  = pn_pkg::OP_CLOSE;
						state_d = ST_FIN;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_FIN: begin
				if (!stat.busy && stat.out_free) begin
					cmd.op  = pn_pkg::OP_FINISH;
					state_d = ST_IDLE;
				end
			end
			ST_RDO: begin
				if (stat.out_free) begin
					cmd.op  = pn_pkg::OP_RD_EMIT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/pn_dp.sv @@
module pn_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pn_pkg::pn_cmd_t         cmd,
	output pn_pkg::pn_stat_t        stat,
	input  pn_pkg::pn_in_t          in_data,
	input  logic [pn_pkg::LEN_W-1:0] out_limit,
	output logic                    out_valid,
	input  logic                    out_ready,
	output pn_pkg::pn_out_t         out_data
);

	localparam int CW  = pn_pkg::CNT_W;
	localparam int AW  = pn_pkg::ADDR_W;
	localparam int SCW = pn_pkg::SC_W;
	localparam int SIW = pn_pkg::SI_W;
	localparam int LW  = pn_pkg::LEN_W;
	localparam int PB  = pn_pkg::PATH_BYTES;
	localparam int SD  = pn_pkg::STK_ENTRIES;

	logic [pn_pkg::CH_W-1:0] store_mem [PB];
	logic [CW-1:0]           stack_mem [SD];

	pn_pkg::pn_in_t  item_q;
	pn_pkg::pn_out_t out_q;
	logic [CW-1:0]   write_pos_q, comp_begin_q, comp_len_q, taken_q, final_len_q;
	logic [SCW-1:0]  stack_cnt_q;
	logic            path_started_q, job_failed_q, done_failed_q;
	logic            comp_dots_q, prev_slash_q, cwd_seen_q;
	logic            pop_pend_q, out_valid_q;
	logic [pn_pkg::CH_W-1:0] store_rd_q;
	logic [CW-1:0]   stack_rd_q;

	logic [CW-1:0]   eff_limit;
	logic            taken_full;
	logic            take_op, take_en, c_slash, char_en;
	logic [pn_pkg::CH_W-1:0] take_c;
	logic            close_go, dots_short, pop_en, comp_go, close_fail, push_ok, stk_push;
	logic [CW:0]     close_end;
	logic [CW-1:0]   slash_pos, char_base;
	logic [CW:0]     char_pos;
	logic            st_we;
	logic [AW-1:0]   st_waddr;
	logic [pn_pkg::CH_W-1:0] st_wdata;
	logic            job_start_en, fin_failed;
	logic [CW-1:0]   fin_len;
	logic            out_free;
	logic [pn_pkg::CH_W-1:0] rd_char;

	assign out_free = !out_valid_q || out_ready;

	assign stat.busy         = pop_pend_q;
	assign stat.out_free     = out_free;
	assign stat.item_cmd     = item_q.cmd;
	assign stat.ch_zero      = (item_q.ch == '0);
	assign stat.ch_slash     = (item_q.ch == pn_pkg::CH_SLASH);
	assign stat.is_cwd       = item_q.is_cwd;
	assign stat.last         = item_q.last;
	assign stat.path_started = path_started_q;
	assign stat.cwd_seen     = cwd_seen_q;
	assign stat.prev_slash   = prev_slash_q;

	assign eff_limit  = ({1'b0, out_limit} > (LW+1)'(PB)) ? CW'(PB) : CW'(out_limit);
	assign taken_full = (taken_q >= CW'(PB - 1));

	assign take_op = (cmd.op == pn_pkg::OP_TAKE_CH) || (cmd.op == pn_pkg::OP_TAKE_CWD) ||
	                 (cmd.op == pn_pkg::OP_TAKE_SL);
	assign take_c  = (cmd.op == pn_pkg::OP_TAKE_SL) ? pn_pkg::CH_SLASH : item_q.ch;
	assign take_en = take_op && !taken_full;
	assign c_slash = (take_c == pn_pkg::CH_SLASH);
	assign char_en = take_en && !c_slash && !job_failed_q;

	// component close: "." dropped, ".." pops, others get a trailing slash
	assign close_go   = ((take_en && c_slash) || (cmd.op == pn_pkg::OP_CLOSE)) &&
	                    !job_failed_q && (comp_len_q != '0);
	assign dots_short = comp_dots_q && (comp_len_q <= CW'(2));
	assign pop_en     = close_go && comp_dots_q && (comp_len_q == CW'(2)) &&
	                    (stack_cnt_q != '0);
	assign comp_go    = close_go && !dots_short;
	assign close_end  = {1'b0, write_pos_q} + {1'b0, comp_len_q} + (CW+1)'(1);
	assign close_fail = (close_end >= {1'b0, eff_limit});
	assign push_ok    = comp_go && !close_fail;
	assign stk_push   = push_ok && (stack_cnt_q < SCW'(SD));
	assign slash_pos  = write_pos_q + comp_len_q;

	assign char_base = (comp_len_q == '0) ? write_pos_q : comp_begin_q;
	assign char_pos  = {1'b0, char_base} + {1'b0, comp_len_q};

	always_comb begin
		st_we    = 1'b0;
		st_waddr = slash_pos[AW-1:0];
		st_wdata = pn_pkg::CH_SLASH;
		if (push_ok) begin
			st_we = 1'b1;
		end else if (char_en && (char_pos < (CW+1)'(PB))) begin
			st_we    = 1'b1;
			st_waddr = char_pos[AW-1:0];
			st_wdata = take_c;
		end
	end

	assign job_start_en = (cmd.op == pn_pkg::OP_JOB_START) || (cmd.op == pn_pkg::OP_FINISH);
	assign fin_failed   = job_failed_q || (eff_limit < CW'(2));
	// slot before write_pos always holds a slash, so it is the trailing one
	assign fin_len      = fin_failed ? '0 :
	                      (write_pos_q > CW'(1)) ? (write_pos_q - CW'(1)) : write_pos_q;

	// slot zero is the root slash, never rewritten
	always_comb begin
		rd_char = '0;
		if (CW'(item_q.index) < final_len_q)
			rd_char = (item_q.index == '0) ? pn_pkg::CH_SLASH : store_rd_q;
	end

	always_ff @(posedge clk) begin
		if (st_we)
			store_mem[st_waddr] <= st_wdata;
		if (cmd.op == pn_pkg::OP_RD_ADDR)
			store_rd_q <= store_mem[item_q.index[AW-1:0]];
		if (stk_push)
			stack_mem[stack_cnt_q[SIW-1:0]] <= write_pos_q;
		if (pop_en)
			stack_rd_q <= stack_mem[SIW'(stack_cnt_q - SCW'(1))];
		if (cmd.load)
			item_q <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_pos_q    <= CW'(1);
			comp_begin_q   <= CW'(1);
			comp_len_q     <= '0;
			taken_q        <= '0;
			final_len_q    <= '0;
			stack_cnt_q    <= '0;
			path_started_q <= 1'b0;
			job_failed_q   <= 1'b0;
			done_failed_q  <= 1'b0;
			comp_dots_q    <= 1'b0;
			prev_slash_q   <= 1'b0;
			cwd_seen_q     <= 1'b0;
			pop_pend_q     <= 1'b0;
		end else begin
			pop_pend_q <= pop_en;
			if (pop_pend_q)
				write_pos_q <= stack_rd_q;
			if (cmd.op == pn_pkg::OP_TAKE_CWD)
				cwd_seen_q <= 1'b1;
			if (take_en) begin
				taken_q      <= taken_q + CW'(1);
				prev_slash_q <= c_slash;
			end
			if (char_en) begin
				if (comp_len_q == '0) begin
					comp_begin_q <= write_pos_q;
					comp_dots_q  <= (take_c == pn_pkg::CH_DOT);
				end else begin
					comp_dots_q <= comp_dots_q && (take_c == pn_pkg::CH_DOT);
				end
				comp_len_q <= comp_len_q + CW'(1);
			end
			if (close_go)
				comp_len_q <= '0;
			if (pop_en)
				stack_cnt_q <= stack_cnt_q - SCW'(1);
			if (comp_go && close_fail)
				job_failed_q <= 1'b1;
			if (stk_push)
				stack_cnt_q <= stack_cnt_q + SCW'(1);
			if (push_ok)
				write_pos_q <= close_end[CW-1:0];
			if (cmd.op == pn_pkg::OP_FINISH) begin
				done_failed_q <= fin_failed;
				final_len_q   <= fin_len;
			end
			if (job_start_en) begin
				write_pos_q    <= CW'(1);
				comp_begin_q   <= CW'(1);
				comp_len_q     <= '0;
				comp_dots_q    <= 1'b0;
				stack_cnt_q    <= '0;
				taken_q        <= '0;
				job_failed_q   <= 1'b0;
				prev_slash_q   <= 1'b0;
				cwd_seen_q     <= 1'b0;
			end
			if (cmd.op == pn_pkg::OP_FINISH)
				path_started_q <= 1'b0;
			else if ((cmd.op == pn_pkg::OP_JOB_START) || (cmd.op == pn_pkg::OP_TAKE_SL) ||
			         (cmd.op == pn_pkg::OP_MARK))
				path_started_q <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.op == pn_pkg::OP_FINISH) || (cmd.op == pn_pkg::OP_RD_EMIT)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == pn_pkg::OP_FINISH) begin
			out_q.status   <= fin_failed;
			out_q.length   <= LW'(fin_len);
			out_q.out_char <= '0;
		end else if (cmd.op == pn_pkg::OP_RD_EMIT) begin
			out_q.status   <= done_failed_q;
			out_q.length   <= LW'(final_len_q);
			out_q.out_char <= rd_char;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ rtl/path_normalizer.sv @@
// Path normalizer. A job streams the working-directory bytes (is_cwd=1) and
// then the path bytes (is_cwd=0), one byte per push transfer (cmd=0); the
// transfer with last=1 ends the job and returns status and length. A leading
// '/' in the path discards the working directory; otherwise the boundary acts
// as a separator. Repeated slashes collapse, "." is dropped, ".." returns to
// the previous component start (no effect at root), and the trailing slash is
// removed. A component that would reach out_limit fails the job (status 1,
// length 0); out_limit below two fails every job. Read transfers (cmd=1)
// return status and length of the last finished job plus the byte at index
// (zero at or past length). One item is processed at a time: a push that
// ends the job also closes the last component and then finishes, a read
// fetches its byte from the store and then emits it, and each ".." that
// pops the component stack waits for the stack memory read. Results wait in
// an output register; a new item is accepted while a result is pending, and
// otherwise the block stalls only when it needs to load the next result.
// Configuration: out_limit at byte address 0, reset 256.
module path_normalizer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pn_pkg::pn_in_t      in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output pn_pkg::pn_out_t     out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int LW = pn_pkg::LEN_W;

	logic [LW-1:0]    out_limit_q;
	logic             reg_sel;
	pn_pkg::pn_cmd_t  cmd;
	pn_pkg::pn_stat_t stat;

	// single register; upper address bit selects nothing
	assign reg_sel = (paddr[2] == 1'b0);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? 32'(out_limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_limit_q <= LW'(256);
		end else if (psel && penable && pwrite && reg_sel) begin
			out_limit_q <= pwdata[LW-1:0];
		end
	end

	pn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pn_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.out_limit (out_limit_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

@@ sim/path_normalizer_test.sv @@
`timescale 1ns / 1ps

// Item and result codes
localparam logic CMD_PUSH = 1'b0;
localparam logic CMD_READ = 1'b1;
localparam logic ST_OK    = 1'b0;
localparam logic ST_FAIL  = 1'b1;

// Tracks the canonical path the block should be building and the replies it owes.
class norm_board_t;
	logic [8:0] limit_reg;
	logic [7:0] store [pn_pkg::PATH_BYTES];
	int         starts [pn_pkg::STK_ENTRIES];
	int         depth, wpos, cbegin, clen, taken, final_len;
	bit         path_started, failed, last_failed, all_dots, prev_slash, cwd_seen;
	pn_pkg::pn_out_t replies [$];
	int         errors;

	function new();
		limit_reg = 9'd256;
		foreach (store[i]) store[i] = 8'h00;
		foreach (starts[i]) starts[i] = 0;
		final_len   = 0;
		last_failed = 1'b0;
		errors      = 0;
		begin_job();
	endfunction

	function int cap();
		return (limit_reg > pn_pkg::PATH_BYTES) ? pn_pkg::PATH_BYTES : int'(limit_reg);
	endfunction

	function void begin_job();
		store[0]     = pn_pkg::CH_SLASH;
		wpos         = 1;
		cbegin       = 1;
		clen         = 0;
		all_dots     = 1'b0;
		depth        = 0;
		taken        = 0;
		failed       = 1'b0;
		prev_slash   = 1'b0;
		cwd_seen     = 1'b0;
		path_started = 1'b0;
	endfunction

	// Close the component under construction: drop ".", pop on "..", else commit.
	function void close_comp();
		int n;
		n = clen;
		if (failed || n == 0) return;
		clen = 0;
		if (all_dots && n == 1) return;
		if (all_dots && n == 2) begin
			if (depth > 0) begin
				depth--;
				wpos = starts[depth];
			end
			return;
		end
		if (wpos + n + 1 >= cap()) begin
			failed = 1'b1;
			return;
		end
		if (depth < pn_pkg::STK_ENTRIES) begin
			starts[depth] = wpos;
			depth++;
		end
		store[wpos + n] = pn_pkg::CH_SLASH;
		wpos += n + 1;
	endfunction

	function void take_byte(logic [7:0] c);
		int pos;
		if (taken >= pn_pkg::PATH_BYTES - 1) return;
		taken++;
		prev_slash = (c == pn_pkg::CH_SLASH);
		if (failed) return;
		if (c == pn_pkg::CH_SLASH) begin
			close_comp();
			return;
		end
		if (clen == 0) begin
			cbegin   = wpos;
			all_dots = 1'b1;
		end
		pos = cbegin + clen;
		if (pos < pn_pkg::PATH_BYTES) store[pos] = c;
		all_dots = all_dots && (c == pn_pkg::CH_DOT);
		clen++;
	endfunction

	function pn_pkg::pn_out_t end_job();
		int              n;
		pn_pkg::pn_out_t r;
		close_comp();
		if (cap() < 2) failed = 1'b1;
		if (failed) begin
			last_failed = 1'b1;
			final_len   = 0;
		end else begin
			n = wpos;
			if (n > 1 && n <= pn_pkg::PATH_BYTES && store[n-1] == pn_pkg::CH_SLASH) n--;
			last_failed = 1'b0;
			final_len   = n;
		end
		begin_job();
		r.status   = last_failed ? ST_FAIL : ST_OK;
		r.length   = 9'(final_len);
		r.out_char = 8'h00;
		return r;
	endfunction

	// Accepted input transfer: advance the prediction, queue any reply it causes.
	function void note_item(pn_pkg::pn_in_t it);
		pn_pkg::pn_out_t r;
		if (it.cmd == CMD_READ) begin
			r.status   = last_failed ? ST_FAIL : ST_OK;
			r.length   = 9'(final_len);
			r.out_char = (int'(it.index) < final_len) ? store[it.index] : 8'h00;
			replies.push_back(r);
			return;
		end
		if (it.ch != 8'h00) begin
			if (it.is_cwd) begin
				if (!path_started) begin
					cwd_seen = 1'b1;
					take_byte(it.ch);
				end
			end else begin
				if (!path_started) begin
					if (it.ch == pn_pkg::CH_SLASH) begin_job();
					else if (!cwd_seen || !prev_slash) take_byte(pn_pkg::CH_SLASH);
					path_started = 1'b1;
				end
				take_byte(it.ch);
			end
		end
		if (it.last) replies.push_back(end_job());
	endfunction

	task report(string what);
		errors++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	task check_reply(pn_pkg::pn_out_t got);
		pn_pkg::pn_out_t want;
		if (replies.size() == 0) begin
			report($sformatf("unexpected result %h", got));
			return;
		end
		want = replies.pop_front();
		if (got.status !== want.status)
			report($sformatf("status got %b want %b", got.status, want.status));
		if (got.length !== want.length)
			report($sformatf("length got %0d want %0d", got.length, want.length));
		if (got.out_char !== want.out_char)
			report($sformatf("out_char got %h want %h", got.out_char, want.out_char));
	endtask
endclass

module path_normalizer_test;

	localparam int          CYCLE_LIMIT    = 600000;
	localparam int          DRAIN_CYCLES   = 30;    // worst item plus a ".." pop, with margin
	localparam int          PHASE_ITEMS    = 110;
	localparam int          PLAN_LEN       = 12;
	localparam int          LONG_HOLD      = 400;
	localparam logic [2:0]  OUT_LIMIT_ADDR = 3'd0;

	typedef enum int {JOB_PLAIN, JOB_DEEP, JOB_LONG} job_kind_t;

	logic            clk;
	logic            arst_n;
	logic            in_valid, in_ready;
	pn_pkg::pn_in_t  in_data;
	logic            out_valid, out_ready;
	pn_pkg::pn_out_t out_data;
	logic            psel, penable, pwrite, pready;
	logic [2:0]      paddr;
	logic [31:0]     pwdata, prdata;

	norm_board_t sb;

	int items_sent;
	int tx_max_gap;   // sender idle per item drawn from 0..tx_max_gap
	int rx_max_gap;   // receiver stall per result drawn from 0..rx_max_gap
	int hold_req;     // one-shot long receiver stall, picked up by the receiver loop

	// out_limit settings walked through, one per random phase; last entry is redrawn
	logic [8:0] limit_plan [PLAN_LEN] = '{9'd256, 9'd0, 9'd1, 9'd2, 9'd3, 9'd7,
		9'd20, 9'd64, 9'd511, 9'd257, 9'd128, 9'd256};

	path_normalizer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends up here.
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("path_normalizer verification failed");
		$finish;
	end

	// Result side. Everything is driven with NBAs at the edge, so values read right
	// after the edge are the ones the block saw.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_reply(out_data);
	end

	// Receiver: random stall before each result transfer, plus the long hold when asked.
	// Exactly one NBA to out_ready per time step.
	initial begin
		int stall;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall    = $urandom_range(0, rx_max_gap) + hold_req;
			hold_req = 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!(out_valid && out_ready)) @(posedge clk);
		end
	end

	// One input transfer. If the next item follows with no gap, valid just stays high.
	task automatic send_item(input pn_pkg::pn_in_t it);
		int gap;
		gap = $urandom_range(0, tx_max_gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_item(it);
		items_sent++;
	endtask

	function automatic pn_pkg::pn_in_t mk_push(logic [7:0] c, logic cwd);
		pn_pkg::pn_in_t it;
		it.cmd    = CMD_PUSH;
		it.ch     = c;
		it.is_cwd = cwd;
		it.last   = 1'b0;
		it.index  = 8'($urandom);   // don't care on a push
		return it;
	endfunction

	task automatic push_byte(input logic [7:0] c, input logic cwd, input logic fin);
		pn_pkg::pn_in_t it;
		it      = mk_push(c, cwd);
		it.last = fin;
		send_item(it);
	endtask

	// Read transfer; the push-only fields carry noise.
	task automatic read_at(input logic [7:0] idx);
		pn_pkg::pn_in_t it;
		it.cmd    = CMD_READ;
		it.ch     = 8'($urandom);
		it.is_cwd = 1'($urandom);
		it.last   = 1'($urandom);
		it.index  = idx;
		send_item(it);
	endtask

	// Mostly slashes, dots and letters so the normalizer sees real paths;
	// the tail covers the whole byte range, zero included.
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return pn_pkg::CH_SLASH;
		if (r < 55) return pn_pkg::CH_DOT;
		if (r < 90) return 8'("a" + $urandom_range(0, 25));
		return 8'($urandom_range(0, 255));
	endfunction

	// Mostly inside the last result, sometimes anywhere
	function automatic logic [7:0] pick_index();
		int hi;
		hi = (sb.final_len > 255) ? 255 : sb.final_len;
		if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, hi));
		return 8'($urandom_range(0, 255));
	endfunction

	// One job: build the push sequence, send it with the occasional read in the middle,
	// then read back a few bytes of the result.
	task automatic run_job();
		pn_pkg::pn_in_t job [$];
		logic [7:0]     c;
		int             n, sel;
		job_kind_t      kind;
		sel  = $urandom_range(0, 59);
		kind = (sel == 0) ? JOB_DEEP : (sel == 1) ? JOB_LONG : JOB_PLAIN;
		case (kind)
			JOB_DEEP: begin
				// 60 to 100 components, often more than the start stack holds, then a run of ".."
				job.push_back(mk_push(pn_pkg::CH_SLASH, 1'b0));
				n = $urandom_range(60, 100);
				repeat (n) begin
					job.push_back(mk_push(8'("a" + $urandom_range(0, 25)), 1'b0));
					job.push_back(mk_push(pn_pkg::CH_SLASH, 1'b0));
				end
				repeat ($urandom_range(1, 8)) begin
					job.push_back(mk_push(pn_pkg::CH_DOT, 1'b0));
					job.push_back(mk_push(pn_pkg::CH_DOT, 1'b0));
					job.push_back(mk_push(pn_pkg::CH_SLASH, 1'b0));
				end
			end
			JOB_LONG: begin
				// one huge component that can hit the output limit and the input byte cap
				if ($urandom_range(0, 1)) job.push_back(mk_push(pn_pkg::CH_SLASH, 1'b0));
				n = $urandom_range(100, 300);
				repeat (n) job.push_back(mk_push(8'("a" + $urandom_range(0, 25)), 1'b0));
			end
			default: begin
				repeat ($urandom_range(0, 8)) job.push_back(mk_push(pick_byte(), 1'b1));
				n = $urandom_range(0, 12);
				for (int i = 0; i < n; i++) begin
					c = (i == 0 && $urandom_range(0, 9) < 3) ? pn_pkg::CH_SLASH : pick_byte();
					// stray working-directory byte after the path began
					if (i > 0 && $urandom_range(0, 24) == 0)
						job.push_back(mk_push(pick_byte(), 1'b1));
					job.push_back(mk_push(c, 1'b0));
				end
			end
		endcase
		if (job.size() == 0) job.push_back(mk_push(8'h00, 1'($urandom)));
		job[job.size()-1].last = 1'b1;
		foreach (job[i]) begin
			send_item(job[i]);
			if (!job[i].last && $urandom_range(0, 19) == 0) read_at(pick_index());
		end
		repeat ($urandom_range(0, 3)) read_at(pick_index());
	endtask

	// Quiet point: input dropped, all replies in, pipeline drained.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write of out_limit, then read it back.
	task automatic write_limit(input logic [8:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= OUT_LIMIT_ADDR;
		pwdata  <= {23'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.limit_reg = v;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[8:0] !== v)
			sb.report($sformatf("out_limit readback %0d want %0d", prdata[8:0], v));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		int         phase_end;
		logic [8:0] lim;
		sb         = new();
		items_sent = 0;
		hold_req   = 0;
		tx_max_gap = 3;
		rx_max_gap = 3;
		arst_n  <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset limit of 256.
		// ".." at root: working dir "x" then path "../.."
		push_byte("x", 1'b1, 1'b0);
		push_byte(pn_pkg::CH_DOT, 1'b0, 1'b0);
		push_byte(pn_pkg::CH_DOT, 1'b0, 1'b0);
		push_byte(pn_pkg::CH_SLASH, 1'b0, 1'b0);
		push_byte(pn_pkg::CH_DOT, 1'b0, 1'b0);
		push_byte(pn_pkg::CH_DOT, 1'b0, 1'b1);
		// zero byte, late working-dir byte, top byte value, "." and trailing slash
		push_byte(pn_pkg::CH_SLASH, 1'b1, 1'b0);
		push_byte(8'h00, 1'b1, 1'b0);
		push_byte("b", 1'b0, 1'b0);
		push_byte("q", 1'b1, 1'b0);
		push_byte(8'hFF, 1'b0, 1'b0);
		push_byte(pn_pkg::CH_SLASH, 1'b0, 1'b0);
		push_byte(pn_pkg::CH_DOT, 1'b0, 1'b0);
		push_byte(pn_pkg::CH_SLASH, 1'b0, 1'b1);
		// working dir only
		push_byte("c", 1'b1, 1'b1);
		// reads inside and past the result
		read_at(8'd0);
		read_at(8'd1);
		read_at(8'hFF);
		// absolute path discards the working dir
		push_byte("z", 1'b1, 1'b0);
		push_byte(pn_pkg::CH_SLASH, 1'b0, 1'b0);
		push_byte("y", 1'b0, 1'b1);
		// read in the middle of a job, then a zero byte that ends it
		push_byte("k", 1'b0, 1'b0);
		read_at(8'd0);
		push_byte(8'h00, 1'b0, 1'b1);

		// Random phases, one out_limit setting each
		for (int p = 0; p < PLAN_LEN; p++) begin
			wait_idle();
			lim = (p == PLAN_LEN - 1) ? 9'($urandom_range(0, 511)) : limit_plan[p];
			write_limit(lim);
			tx_max_gap = ($urandom_range(0, 2) == 0) ? 0 : 16;
			rx_max_gap = ($urandom_range(0, 2) == 0) ? 0 : 16;
			if (p == 0) begin
				// back-pressure: receiver goes quiet while the sender keeps going
				tx_max_gap = 0;
				hold_req   = LONG_HOLD;
			end
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) run_job();
		end

		wait_idle();
		if (sb.errors == 0) begin
			$display("path_normalizer verification clean");
		end else begin
			$display("path_normalizer verification failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/pn_pkg.sv
rtl/pn_ctrl.sv
rtl/pn_dp.sv
rtl/path_normalizer.sv
sim/path_normalizer_test.sv
